// File: sv/omt_pkg.sv
// Shared types and constants of the ordered multiset table.
// Holds request codes, field widths, and the controller/datapath command and status structs.
package omt_pkg;

   localparam int CAPACITY_DEFAULT   = 16;
   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int MAX_VALUE_BITS     = 64;
   localparam int MAX_CNT_BITS       = 16;

   localparam int REQ_BITS   = 3;
   localparam int ITEM_BITS  = 32;
   localparam int FIELD_BITS = 5;

   localparam logic [REQ_BITS-1:0] REQ_ADD      = 3'd0;
   localparam logic [REQ_BITS-1:0] REQ_REMOVE   = 3'd1;
   localparam logic [REQ_BITS-1:0] REQ_CONTAINS = 3'd2;
   localparam logic [REQ_BITS-1:0] REQ_FREQ     = 3'd3;
   localparam logic [REQ_BITS-1:0] REQ_CLEAR    = 3'd4;

   typedef struct packed {
      logic accept;
      logic scan;
      logic shift;
      logic finish;
   } omt_cmd_type;

   typedef struct packed {
      logic search_op;
      logic scan_end;
      logic go_shift;
      logic shift_end;
      logic rsp_free;
   } omt_status_type;

endpackage

// File: sv/ordered_multiset_table.sv
// Ordered multiset table, top level: controller and datapath.
// Depends on omt_pkg, omt_ctrl, omt_datapath (which holds omt_ram).
//
// Bounded ordered bag of up to CAPACITY values held in a two-read-port RAM. One request
// at a time; each gives one response beat. Add, clear and unknown codes skip the search.
// Contains and frequency walk the table one step per cycle through the RAM read ports,
// and a contains walk stops early on a hit. Remove stops its search at the first match
// and then closes up the later entries, one per cycle. A new request is taken once the
// previous one has reached the response register, even while that beat is still
// stalled. Adding to a full table returns success low and leaves the table unchanged.
// No clearing pass after reset.
module ordered_multiset_table
   import omt_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [REQ_BITS-1:0]   req_type,
   input  logic [ITEM_BITS-1:0]  req_item_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_success,
   output logic [FIELD_BITS-1:0] rsp_copies,
   output logic [FIELD_BITS-1:0] rsp_occupancy
);

   omt_cmd_type    cmd;
   omt_status_type status;

   omt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   omt_datapath #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_type       (req_type),
      .req_item_value (req_item_value),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_success    (rsp_success),
      .rsp_copies     (rsp_copies),
      .rsp_occupancy  (rsp_occupancy),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

// File: sv/omt_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module omt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en_a,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   rd_addr_a,
   output logic [WIDTH-1:0]                           rd_data_a,
   input  logic                                       rd_en_b,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   rd_addr_b,
   output logic [WIDTH-1:0]                           rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en_a) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: sv/omt_ctrl.sv
// Controller of the ordered multiset table: request sequencing state machine.
// Depends on omt_pkg for the command and status structs.
module omt_ctrl
   import omt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  omt_status_type status,
   output omt_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_SHIFT  = 4'b0100,
      ST_DONE   = 4'b1000
   } omt_state_type;

   omt_state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = status.search_op ? ST_SEARCH : ST_DONE;
            end
         end
         ST_SEARCH: begin
            cmd.scan = 1'b1;
            if (status.scan_end) begin
               state_in = status.go_shift ? ST_SHIFT : ST_DONE;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (status.shift_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.finish = status.rsp_free;
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// File: sv/omt_datapath.sv
// Datapath of the ordered multiset table: entry RAM, count, search and close-up logic,
// response register. Depends on omt_pkg and omt_ram.
module omt_datapath
   import omt_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_BITS-1:0]   req_type,
   input  logic [ITEM_BITS-1:0]  req_item_value,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic                  rsp_success,
   output logic [FIELD_BITS-1:0] rsp_copies,
   output logic [FIELD_BITS-1:0] rsp_occupancy,
   input  omt_cmd_type           cmd,
   output omt_status_type        status
);

   localparam int IDX_BITS = $clog2(CAPACITY > 1 ? CAPACITY : 2);
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);
   localparam logic [CNT_BITS-1:0] CNT_CAP = CNT_BITS'(CAPACITY);

   logic [REQ_BITS-1:0]   op_ff, op_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   rd_idx_ff, rd_idx_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [CNT_BITS-1:0]   chk_idx_ff, chk_idx_in;
   logic                  sh_vld_ff, sh_vld_in;
   logic [CNT_BITS-1:0]   wr_idx_ff, wr_idx_in;
   logic                  success_ff, success_in;
   logic [CNT_BITS-1:0]   copies_ff, copies_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_success_ff, rsp_success_in;
   logic [FIELD_BITS-1:0] rsp_copies_ff, rsp_copies_in;
   logic [FIELD_BITS-1:0] rsp_occupancy_ff, rsp_occupancy_in;

   logic                  ram_wr_en;
   logic [IDX_BITS-1:0]   ram_wr_addr;
   logic [VALUE_BITS-1:0] ram_wr_data;
   logic                  ram_rd_en_a, ram_rd_en_b;
   logic [IDX_BITS-1:0]   ram_rd_addr_a, ram_rd_addr_b;
   logic [VALUE_BITS-1:0] ram_rd_data_a, ram_rd_data_b;

   logic [MAX_VALUE_BITS-1:0] wide_val;
   logic [VALUE_BITS-1:0]     req_val;
   logic [MAX_CNT_BITS-1:0]   wide_copies;
   logic [MAX_CNT_BITS-1:0]   wide_count;
   logic                      head_hit, tail_hit, hit, last_step, issue, is_freq;
   logic [CNT_BITS-1:0]       back_chk, back_rd, hit_pos;

   omt_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_en_a   (ram_rd_en_a),
      .rd_addr_a (ram_rd_addr_a),
      .rd_data_a (ram_rd_data_a),
      .rd_en_b   (ram_rd_en_b),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_b (ram_rd_data_b)
   );

   assign wide_val    = {{(MAX_VALUE_BITS-ITEM_BITS){1'b0}}, req_item_value};
   assign req_val     = wide_val[VALUE_BITS-1:0];
   assign wide_copies = {{(MAX_CNT_BITS-CNT_BITS){1'b0}}, copies_ff};
   assign wide_count  = {{(MAX_CNT_BITS-CNT_BITS){1'b0}}, count_ff};

   // check stage compares the pair read in the previous cycle
   assign is_freq   = (op_ff == REQ_FREQ);
   assign head_hit  = chk_vld_ff && (ram_rd_data_a == val_ff);
   assign tail_hit  = chk_vld_ff && (ram_rd_data_b == val_ff);
   assign hit       = !is_freq && (head_hit || tail_hit);
   assign last_step = chk_vld_ff && (chk_idx_ff == count_ff - CNT_ONE);
   assign back_chk  = count_ff - CNT_ONE - chk_idx_ff;
   assign back_rd   = count_ff - CNT_ONE - rd_idx_ff;
   assign hit_pos   = head_hit ? chk_idx_ff : back_chk;
   assign issue     = (rd_idx_ff < count_ff);

   always_comb begin
      status.search_op = (req_type == REQ_REMOVE) || (req_type == REQ_CONTAINS) ||
                         (req_type == REQ_FREQ);
      status.scan_end  = (count_ff == '0) || last_step || hit;
      status.go_shift  = hit && (op_ff == REQ_REMOVE);
      status.shift_end = !issue;
      status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      op_in            = op_ff;
      val_in           = val_ff;
      count_in         = count_ff;
      rd_idx_in        = rd_idx_ff;
      chk_vld_in       = chk_vld_ff;
      chk_idx_in       = chk_idx_ff;
      sh_vld_in        = sh_vld_ff;
      wr_idx_in        = wr_idx_ff;
      success_in       = success_ff;
      copies_in        = copies_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_success_in   = rsp_success_ff;
      rsp_copies_in    = rsp_copies_ff;
      rsp_occupancy_in = rsp_occupancy_ff;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = count_ff[IDX_BITS-1:0];
      ram_wr_data      = req_val;
      ram_rd_en_a      = 1'b0;
      ram_rd_en_b      = 1'b0;
      ram_rd_addr_a    = rd_idx_ff[IDX_BITS-1:0];
      ram_rd_addr_b    = back_rd[IDX_BITS-1:0];

      if (cmd.accept) begin
         op_in      = req_type;
         val_in     = req_val;
         rd_idx_in  = '0;
         chk_vld_in = 1'b0;
         sh_vld_in  = 1'b0;
         success_in = 1'b0;
         copies_in  = '0;
         case (req_type)
            REQ_ADD: begin
               if (count_ff < CNT_CAP) begin
                  ram_wr_en  = 1'b1;
                  count_in   = count_ff + CNT_ONE;
                  success_in = 1'b1;
               end
            end
            REQ_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.scan) begin
         ram_rd_en_a = issue;
         ram_rd_en_b = issue;
         chk_vld_in  = issue;
         chk_idx_in  = rd_idx_ff;
         if (issue) begin
            rd_idx_in = rd_idx_ff + CNT_ONE;
         end
         if (is_freq && head_hit) begin
            copies_in  = copies_ff + CNT_ONE;
            success_in = 1'b1;
         end
         if (hit) begin
            success_in = 1'b1;
            chk_vld_in = 1'b0;
         end
         if (status.go_shift) begin
            rd_idx_in = hit_pos + CNT_ONE;
            sh_vld_in = 1'b0;
         end
      end

      // close-up: read entry r, write it to r-1 a beat later
      if (cmd.shift) begin
         ram_rd_en_a = issue;
         sh_vld_in   = issue;
         wr_idx_in   = rd_idx_ff - CNT_ONE;
         if (issue) begin
            rd_idx_in = rd_idx_ff + CNT_ONE;
         end else begin
            count_in = count_ff - CNT_ONE;
         end
         if (sh_vld_ff) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wr_idx_ff[IDX_BITS-1:0];
            ram_wr_data = ram_rd_data_a;
         end
      end

      if (cmd.finish) begin
         rsp_valid_in     = 1'b1;
         rsp_success_in   = success_ff;
         rsp_copies_in    = wide_copies[FIELD_BITS-1:0];
         rsp_occupancy_in = wide_count[FIELD_BITS-1:0];
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         sh_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         sh_vld_ff    <= sh_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      val_ff           <= val_in;
      rd_idx_ff        <= rd_idx_in;
      chk_idx_ff       <= chk_idx_in;
      wr_idx_ff        <= wr_idx_in;
      success_ff       <= success_in;
      copies_ff        <= copies_in;
      rsp_success_ff   <= rsp_success_in;
      rsp_copies_ff    <= rsp_copies_in;
      rsp_occupancy_ff <= rsp_occupancy_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_success   = rsp_success_ff;
   assign rsp_copies    = rsp_copies_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_CAP)
      else $error("entry count above capacity");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.shift && sh_vld_ff) |-> (wr_idx_ff + CNT_ONE < count_ff))
      else $error("close-up write outside held entries");

   a_scan_holds_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && !status.scan_end) |=> $stable(count_ff))
      else $error("entry count changed during search");

   a_copies_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (copies_ff <= count_ff))
      else $error("copy count above entry count");

endmodule
